// ===== rtl/core/xksd_pkg.sv =====
// Shared constants and types of the XOR key stream decrypter.
`default_nettype none
package xksd_pkg;

   localparam int DATA_W           = 8;
   localparam int STATUS_W         = 2;
   localparam int LEN_W            = 6;
   localparam int WORD_W           = 64;
   localparam int PASS_WORDS       = 4;
   localparam int PASS_BYTES       = PASS_WORDS * WORD_W / DATA_W;
   localparam int PASS_IDX_W       = $clog2(PASS_BYTES);
   localparam int CHECK_WORD_BYTES = 8;
   localparam int CHECK_WORDS      = 3;
   localparam int CHECK_BYTES      = CHECK_WORDS * CHECK_WORD_BYTES;
   localparam int CHK_IDX_W        = $clog2(CHECK_BYTES);
   localparam int BYTE_SEL_W       = $clog2(CHECK_WORD_BYTES);
   localparam int HALF_W           = WORD_W / 2;
   localparam int DEF_MAX_KEY_BYTES = 32;

   localparam int CSR_IDX_W  = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PASS_WORD0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PASS_WORD1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PASS_WORD2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PASS_WORD3 = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FAIL  = 2'd2;

   // Check word selectors.
   localparam logic [1:0] WORD_A = 2'd0;
   localparam logic [1:0] WORD_B = 2'd1;
   localparam logic [1:0] WORD_C = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0]   plain_byte;
      logic [STATUS_W-1:0] status;
      logic                end_of_run;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/core/xor_key_stream_decrypter_unit.sv =====
// Streaming XOR decrypter with session-key header and multiply check.
// Encrypted bytes arrive on the req_ stream, one per transaction, req_tlast
// marking the final byte of a message. Decrypted bytes leave on the rsp_
// stream with the status code on rsp_tuser and rsp_tlast on the last result.
// The first key_length bytes of a message recover the session key, and the
// next 24 bytes give the check words a, b and c; none of these gives a result
// unless the message ends there (too short) or a*b differs from c (check
// failed, rest of message dropped). Later bytes each give one data result.
// A byte is taken every cycle while req_tready is high; its result is registered
// before it leaves. The a*b product comes from a two-stage multiplier started
// once a and b are complete, so it is ready before the last byte of c.
// When the receiver stalls, a skid entry absorbs one more result and then
// req_tready drops until the result register drains.
// Reset is synchronous: key_length returns to 1, the passphrase to zero, the
// message position to its start; the stored session key is left as is.
// The user writes configuration through csr_we, csr_index and csr_wdata only
// while no message byte is in flight; the block itself does not enforce this.
`default_nettype none
module xor_key_stream_decrypter_unit #(
   parameter int MAX_KEY_BYTES = xksd_pkg::DEF_MAX_KEY_BYTES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [xksd_pkg::DATA_W-1:0]     req_tdata,   // [7:0] cipher_byte
   input  wire logic                            req_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [xksd_pkg::DATA_W-1:0]     rsp_tdata,   // [7:0] plain_byte
   output logic      [xksd_pkg::STATUS_W-1:0]   rsp_tuser,   // [1:0] status
   output logic                                 rsp_tlast,
   input  wire logic                            csr_we,
   input  wire logic [xksd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [xksd_pkg::WORD_W-1:0]     csr_wdata
);

   localparam int KI_W  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int LW    = xksd_pkg::LEN_W;
   localparam int DW    = xksd_pkg::DATA_W;
   localparam int WW    = xksd_pkg::WORD_W;
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_KEY_BYTES);
   localparam logic [LW:0]   CHK_LEN = (LW + 1)'(xksd_pkg::CHECK_BYTES);
   localparam logic [xksd_pkg::CHK_IDX_W-1:0] LAST_CHK =
      xksd_pkg::CHK_IDX_W'(xksd_pkg::CHECK_BYTES - 1);

   // Configuration registers.
   logic [LW-1:0]                              key_len_ff;
   logic [xksd_pkg::PASS_WORDS-1:0][WW-1:0]    pass_ff;
   logic [xksd_pkg::PASS_BYTES-1:0][DW-1:0]    pass_bytes;

   // Message state.
   logic [LW-1:0]                              hdr_ff, hdr_in;
   logic [KI_W-1:0]                            ki_ff, ki_in;
   logic [xksd_pkg::CHECK_WORDS-1:0][WW-1:0]   cw_ff, cw_in;
   logic                                       drop_ff, drop_in;
   logic [DW-1:0]                              key_ff [MAX_KEY_BYTES];

   logic [LW-1:0]                    len;
   logic [LW-1:0]                    ki_inc;
   logic [KI_W-1:0]                  ki_next;
   logic                             in_key_phase;
   logic                             in_chk_phase;
   logic [xksd_pkg::CHK_IDX_W-1:0]   chk_pos;
   logic [1:0]                       chk_word;
   logic [xksd_pkg::BYTE_SEL_W-1:0]  chk_byte;
   logic                             last_chk;
   logic [DW-1:0]                    key_byte;
   logic [DW-1:0]                    dec_byte;
   logic [DW-1:0]                    pass_byte;
   logic                             key_we;
   logic                             ab_load;
   logic [WW-1:0]                    prod;
   logic                             prod_ready;
   logic                             stall;
   logic                             skid_ready;
   logic                             accept;
   logic                             res_valid;
   xksd_pkg::rsp_type                res;
   xksd_pkg::rsp_type                rsp_data;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff <= LW'(1);
         pass_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            xksd_pkg::REG_KEY_LENGTH: key_len_ff <= csr_wdata[LW-1:0];
            xksd_pkg::REG_PASS_WORD0: pass_ff[0] <= csr_wdata;
            xksd_pkg::REG_PASS_WORD1: pass_ff[1] <= csr_wdata;
            xksd_pkg::REG_PASS_WORD2: pass_ff[2] <= csr_wdata;
            xksd_pkg::REG_PASS_WORD3: pass_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign pass_bytes = pass_ff;

   // A key length of zero acts as one, and lengths beyond the store are clamped.
   always_comb begin
      if (key_len_ff == '0) begin
         len = LW'(1);
      end else if (key_len_ff > MAX_LEN) begin
         len = MAX_LEN;
      end else begin
         len = key_len_ff;
      end
   end

   assign in_key_phase = (hdr_ff < len);
   assign in_chk_phase = !in_key_phase && ({1'b0, hdr_ff} < ({1'b0, len} + CHK_LEN));
   assign chk_pos      = xksd_pkg::CHK_IDX_W'(hdr_ff - len);
   assign chk_word     = 2'(chk_pos / xksd_pkg::CHECK_WORD_BYTES);
   assign chk_byte     = xksd_pkg::BYTE_SEL_W'(chk_pos % xksd_pkg::CHECK_WORD_BYTES);
   assign last_chk     = (chk_pos == LAST_CHK);

   assign ki_inc   = LW'(ki_ff) + LW'(1);
   assign ki_next  = (ki_inc >= len) ? '0 : KI_W'(ki_inc);
   assign key_byte = key_ff[ki_ff];
   assign dec_byte = req_tdata ^ key_byte;
   assign pass_byte = pass_bytes[hdr_ff[xksd_pkg::PASS_IDX_W-1:0]];

   // Hold the last check byte back until the product matches the current a and b.
   assign stall      = !drop_ff && in_chk_phase && last_chk && !prod_ready;
   assign req_tready = skid_ready && !stall;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      hdr_in    = hdr_ff;
      ki_in     = ki_ff;
      cw_in     = cw_ff;
      drop_in   = drop_ff;
      key_we    = 1'b0;
      ab_load   = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      if (accept) begin
         ki_in = ki_next;
         if (!drop_ff) begin
            if (in_key_phase) begin
               key_we = 1'b1;
               hdr_in = hdr_ff + LW'(1);
               if (req_tlast) begin
                  res_valid      = 1'b1;
                  res.status     = xksd_pkg::ST_SHORT;
                  res.end_of_run = 1'b1;
               end
            end else if (in_chk_phase) begin
               hdr_in = hdr_ff + LW'(1);
               case (chk_word)
                  xksd_pkg::WORD_A: begin
                     cw_in[0][chk_byte*DW +: DW] = dec_byte;
                     ab_load = 1'b1;
                  end
                  xksd_pkg::WORD_B: begin
                     cw_in[1][chk_byte*DW +: DW] = dec_byte;
                     ab_load = 1'b1;
                  end
                  xksd_pkg::WORD_C: begin
                     cw_in[2][chk_byte*DW +: DW] = dec_byte;
                  end
                  default: ;
               endcase
               if (req_tlast) begin
                  res_valid      = 1'b1;
                  res.status     = xksd_pkg::ST_SHORT;
                  res.end_of_run = 1'b1;
               end else if (last_chk && (prod != cw_in[2])) begin
                  res_valid      = 1'b1;
                  res.status     = xksd_pkg::ST_FAIL;
                  res.end_of_run = 1'b1;
                  drop_in        = 1'b1;
               end
            end else begin
               res_valid      = 1'b1;
               res.plain_byte = dec_byte;
               res.status     = xksd_pkg::ST_OK;
               res.end_of_run = req_tlast;
            end
         end
         if (req_tlast) begin
            hdr_in  = '0;
            ki_in   = '0;
            cw_in   = '0;
            drop_in = 1'b0;
            ab_load = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff  <= '0;
         ki_ff   <= '0;
         cw_ff   <= '0;
         drop_ff <= 1'b0;
      end else begin
         hdr_ff  <= hdr_in;
         ki_ff   <= ki_in;
         cw_ff   <= cw_in;
         drop_ff <= drop_in;
      end
   end

   // Session key store: written during the key header, read at the key index.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_ff[hdr_ff[KI_W-1:0]] <= req_tdata ^ pass_byte;
      end
   end

   xksd_mul64 u_mul (
      .clock (clock),
      .reset (reset),
      .load  (ab_load),
      .a     (cw_ff[0]),
      .b     (cw_ff[1]),
      .prod  (prod),
      .ready (prod_ready)
   );

   xksd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .in_ready  (skid_ready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_data),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = rsp_data.plain_byte;
   assign rsp_tuser = rsp_data.status;
   assign rsp_tlast = rsp_data.end_of_run;

endmodule
`default_nettype wire

// ===== rtl/core/xksd_mul64.sv =====
// Two-stage 64-bit multiplier giving the low product word, with a ready flag.
`default_nettype none
module xksd_mul64 (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic [xksd_pkg::WORD_W-1:0]   a,
   input  wire logic [xksd_pkg::WORD_W-1:0]   b,
   output logic      [xksd_pkg::WORD_W-1:0]   prod,
   output logic                               ready
);

   localparam int HW = xksd_pkg::HALF_W;
   localparam int WW = xksd_pkg::WORD_W;
   localparam logic [1:0] PIPE_CYCLES = 2'd2;

   logic [WW-1:0] ll_ff, ll_in;
   logic [HW-1:0] lh_ff, lh_in;
   logic [HW-1:0] hl_ff, hl_in;
   logic [WW-1:0] prod_ff, prod_in;
   logic [1:0]    cnt_ff, cnt_in;

   // The low 64 bits of the product need the full low-low term and only the cross terms' low halves.
   always_comb begin
      ll_in   = a[HW-1:0] * b[HW-1:0];
      lh_in   = a[HW-1:0] * b[WW-1:HW];
      hl_in   = a[WW-1:HW] * b[HW-1:0];
      prod_in = ll_ff + {lh_ff + hl_ff, {HW{1'b0}}};
   end

   // The product is trusted only once both stages have seen the current operands.
   always_comb begin
      if (load) begin
         cnt_in = PIPE_CYCLES;
      end else if (cnt_ff != 2'd0) begin
         cnt_in = cnt_ff - 2'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      ll_ff   <= ll_in;
      lh_ff   <= lh_in;
      hl_ff   <= hl_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= PIPE_CYCLES;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign prod  = prod_ff;
   assign ready = (cnt_ff == 2'd0);

endmodule
`default_nettype wire

// ===== rtl/core/xksd_skid.sv =====
// Result register with a skid entry, so the input side never waits on rsp_tready directly.
`default_nettype none
module xksd_skid (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire xksd_pkg::rsp_type push_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output xksd_pkg::rsp_type      out_data,
   input  wire logic              out_ready
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   xksd_pkg::rsp_type main_ff, main_in;
   xksd_pkg::rsp_type skid_ff, skid_in;
   logic              pop;

   assign pop = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule
`default_nettype wire
